// ----- rtl/rfcp_pkg.sv -----
// Shared types, constants and the CRC byte update for the remote frame parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rfcp_pkg;

    localparam int FRAME_LEN   = 21;
    localparam int PAYLOAD_LEN = 17;
    localparam int PAY_W       = PAYLOAD_LEN * 8;
    localparam int CNT_W       = 5;
    localparam int CRC_W       = 16;
    localparam int CFG_IDX_W   = 8;

    // Byte positions inside a frame; the payload starts after the two header bytes.
    localparam logic [CNT_W-1:0] CNT_HDR_DONE = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_CRC_LO   = CNT_W'(19);
    localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(FRAME_LEN - 1);

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

    localparam logic [7:0] HDR_FIRST_RST  = 8'hA9;
    localparam logic [7:0] HDR_SECOND_RST = 8'h53;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_SECOND = CFG_IDX_W'(1);

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SECOND,
        PH_COLLECT
    } t_phase;

    typedef struct packed {
        logic done;
        logic crc_ok;
    } t_frame_evt;

    // Reflected CRC-16 update, one byte taken LSB first.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in;
        for (int j = 0; j < 8; j++) begin
            if (crc[0] ^ data[j]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/rfcp_framer.sv -----
// Header hunt, byte counting, running CRC and frame byte storage.
// Depends on rfcp_pkg for the phase type, the event struct and crc_feed.
`timescale 1ns / 1ps

module rfcp_framer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_command,
    input  logic [7:0]               i_rx_byte,
    input  logic [7:0]               i_header_first,
    input  logic [7:0]               i_header_second,
    output rfcp_pkg::t_frame_evt     o_evt,
    output logic                     o_at_last,
    output logic [rfcp_pkg::PAY_W-1:0] o_payload
);
    import rfcp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CRC_W-1:0] r_crc, n_crc;
    logic             r_burst, n_burst;
    logic [7:0]       r_frame [PAYLOAD_LEN];
    logic [7:0]       r_crc_lo;
    logic             w_byte;
    logic             w_store;

    assign w_byte  = i_accept && (i_command == CMD_BYTE) && !r_burst;
    assign w_store = w_byte && (r_phase == PH_COLLECT);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_crc   = r_crc;
        n_burst = r_burst;
        if (i_accept && (i_command == CMD_IDLE)) begin
            n_phase = PH_HUNT;
            n_count = '0;
            n_crc   = CRC_INIT;
            n_burst = 1'b0;
        end else if (w_byte) begin
            case (r_phase)
                PH_SECOND, PH_HUNT: begin
                    if ((r_phase == PH_SECOND) && (i_rx_byte == i_header_second)) begin
                        n_phase = PH_COLLECT;
                        n_count = CNT_HDR_DONE;
                        n_crc   = crc_feed(r_crc, i_rx_byte);
                    end else if (i_rx_byte == i_header_first) begin
                        // Otherwise a first header byte (re)starts a frame.
                        n_phase = PH_SECOND;
                        n_count = CNT_W'(1);
                        n_crc   = crc_feed(CRC_INIT, i_rx_byte);
                    end else begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_crc   = CRC_INIT;
                    end
                end
                PH_COLLECT: begin
                    if (r_count == CNT_LAST) begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_crc   = CRC_INIT;
                        n_burst = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        if (r_count < CNT_CRC_LO) begin
                            n_crc = crc_feed(r_crc, i_rx_byte);
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_count = '0;
                    n_crc   = CRC_INIT;
                end
            endcase
        end
    end

    always_comb begin
        o_evt.done   = w_store && (r_count == CNT_LAST);
        o_evt.crc_ok = (r_crc == {i_rx_byte, r_crc_lo});
        o_at_last    = (r_phase == PH_COLLECT) && (r_count == CNT_LAST) && !r_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_burst <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_burst <= n_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
            if (w_store && (r_count == CNT_HDR_DONE + CNT_W'(k))) begin
                r_frame[k] <= i_rx_byte;
            end
        end
        if (w_store && (r_count == CNT_CRC_LO)) begin
            r_crc_lo <= i_rx_byte;
        end
    end

    always_comb begin
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
            o_payload[k*8 +: 8] = r_frame[k];
        end
    end

endmodule

// ----- rtl/rfcp_result.sv -----
// Result register: last good payload, status and output valid, plus field decode.
// Depends on rfcp_pkg for the event struct and payload width.
`timescale 1ns / 1ps

module rfcp_result (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rfcp_pkg::t_frame_evt       i_evt,
    input  logic [rfcp_pkg::PAY_W-1:0] i_payload,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_status,
    output logic [10:0]                o_right_horizontal,
    output logic [10:0]                o_right_vertical,
    output logic [10:0]                o_left_vertical,
    output logic [10:0]                o_left_horizontal,
    output logic [10:0]                o_thumb_wheel,
    output logic [5:0]                 o_switch_bits,
    output logic signed [15:0]         o_pointer_dx,
    output logic signed [15:0]         o_pointer_dy,
    output logic signed [15:0]         o_pointer_dz,
    output logic [2:0]                 o_pointer_buttons,
    output logic [15:0]                o_key_mask
);
    import rfcp_pkg::*;

    logic             r_valid;
    logic             r_status;
    logic [PAY_W-1:0] r_good;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= 1'b0;
            r_good   <= '0;
        end else begin
            if (i_evt.done) begin
                r_valid  <= 1'b1;
                r_status <= !i_evt.crc_ok;
                if (i_evt.crc_ok) begin
                    r_good <= i_payload;
                end
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Bit offsets count from the first payload bit (frame bit 16), LSB first.
    always_comb begin
        o_out_valid        = r_valid;
        o_status           = r_status;
        o_right_horizontal = r_good[10:0];
        o_right_vertical   = r_good[21:11];
        o_left_vertical    = r_good[32:22];
        o_left_horizontal  = r_good[43:33];
        o_thumb_wheel      = r_good[59:49];
        o_switch_bits      = {r_good[60], r_good[48], r_good[47], r_good[46], r_good[45:44]};
        o_pointer_dx       = r_good[79:64];
        o_pointer_dy       = r_good[95:80];
        o_pointer_dz       = r_good[111:96];
        o_pointer_buttons  = {(r_good[117:116] == 2'b01),
                              (r_good[115:114] == 2'b01),
                              (r_good[113:112] == 2'b01)};
        o_key_mask         = r_good[135:120];
    end

endmodule

// ----- rtl/remote_frame_crc_parser_core.sv -----
// Top level of the remote frame parser: handshakes, header registers, framer and result.
// Depends on rfcp_pkg, rfcp_framer and rfcp_result.
`timescale 1ns / 1ps

// Each accepted word is either a received byte or a line-idle event, and the parser
// takes one word per clock cycle unless stalled as below; the whole per-byte step,
// including the unrolled 8-bit CRC-16 update, is combinational logic between the state
// registers. A result appears registered on the cycle after the last byte of the first
// complete frame of a burst and stays until taken; while it waits, every word is still
// accepted until a following frame reaches its last byte, and the word in that position
// waits for the result to be taken. No clearing pass is needed after reset.
module remote_frame_crc_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_command,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_status,
    output logic [10:0]                    o_right_horizontal,
    output logic [10:0]                    o_right_vertical,
    output logic [10:0]                    o_left_vertical,
    output logic [10:0]                    o_left_horizontal,
    output logic [10:0]                    o_thumb_wheel,
    output logic [5:0]                     o_switch_bits,
    output logic signed [15:0]             o_pointer_dx,
    output logic signed [15:0]             o_pointer_dy,
    output logic signed [15:0]             o_pointer_dz,
    output logic [2:0]                     o_pointer_buttons,
    output logic [15:0]                    o_key_mask,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import rfcp_pkg::*;

    logic [7:0]       r_hdr_first;
    logic [7:0]       r_hdr_second;
    t_frame_evt       w_evt;
    logic             w_at_last;
    logic             w_accept;
    logic [PAY_W-1:0] w_payload;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HDR_FIRST_RST;
            r_hdr_second <= HDR_SECOND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_HDR_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_IDX_HDR_SECOND: r_hdr_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Only the word that would complete a frame has to wait for the result slot.
    assign o_in_ready = !o_out_valid || i_out_ready || !w_at_last;
    assign w_accept   = i_in_valid && o_in_ready;

    rfcp_framer u_framer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .i_header_first (r_hdr_first),
        .i_header_second(r_hdr_second),
        .o_evt          (w_evt),
        .o_at_last      (w_at_last),
        .o_payload      (w_payload)
    );

    rfcp_result u_result (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_evt             (w_evt),
        .i_payload         (w_payload),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_right_horizontal(o_right_horizontal),
        .o_right_vertical  (o_right_vertical),
        .o_left_vertical   (o_left_vertical),
        .o_left_horizontal (o_left_horizontal),
        .o_thumb_wheel     (o_thumb_wheel),
        .o_switch_bits     (o_switch_bits),
        .o_pointer_dx      (o_pointer_dx),
        .o_pointer_dy      (o_pointer_dy),
        .o_pointer_dz      (o_pointer_dz),
        .o_pointer_buttons (o_pointer_buttons),
        .o_key_mask        (o_key_mask)
    );

`ifndef SYNTHESIS
    // A pending result is never overwritten by a new frame.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_evt.done)
        else $error("frame completed while a result was still pending");

    // Only one frame per burst is taken.
    a_one_per_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evt.done |=> !w_evt.done)
        else $error("two frames taken in one burst");

    // Input back-pressure only comes from a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && w_at_last))
        else $error("input stalled without a pending result");
`endif

endmodule

// ----- tb/remote_frame_crc_parser_core_test.sv -----
// Self-checking testbench for remote_frame_crc_parser_core: header hunt, CRC check and
// field decode, with random idling on both handshakes. Depends on rfcp_pkg and the RTL.
`timescale 1ns / 1ps

module remote_frame_crc_parser_core_test;
    import rfcp_pkg::*;

    typedef struct {
        logic               status;
        logic [10:0]        right_h;
        logic [10:0]        right_v;
        logic [10:0]        left_v;
        logic [10:0]        left_h;
        logic [10:0]        wheel;
        logic [5:0]         switches;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [2:0]         buttons;
        logic [15:0]        keys;
    } t_stick_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command;
    logic [7:0]           i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_status;
    logic [10:0]          o_right_horizontal;
    logic [10:0]          o_right_vertical;
    logic [10:0]          o_left_vertical;
    logic [10:0]          o_left_horizontal;
    logic [10:0]          o_thumb_wheel;
    logic [5:0]           o_switch_bits;
    logic signed [15:0]   o_pointer_dx;
    logic signed [15:0]   o_pointer_dy;
    logic signed [15:0]   o_pointer_dz;
    logic [2:0]           o_pointer_buttons;
    logic [15:0]          o_key_mask;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    remote_frame_crc_parser_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_right_horizontal (o_right_horizontal),
        .o_right_vertical   (o_right_vertical),
        .o_left_vertical    (o_left_vertical),
        .o_left_horizontal  (o_left_horizontal),
        .o_thumb_wheel      (o_thumb_wheel),
        .o_switch_bits      (o_switch_bits),
        .o_pointer_dx       (o_pointer_dx),
        .o_pointer_dy       (o_pointer_dy),
        .o_pointer_dz       (o_pointer_dz),
        .o_pointer_buttons  (o_pointer_buttons),
        .o_key_mask         (o_key_mask),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Parser mirror, advanced on every accepted word.
    logic [7:0]       hdr_first_q;
    logic [7:0]       hdr_second_q;
    t_phase           hunt_q;
    int               fill_q;
    logic [CRC_W-1:0] crc_q;
    logic [7:0]       frame_q [FRAME_LEN];
    logic [7:0]       last_good_q [PAYLOAD_LEN];
    logic             burst_done_q;

    t_stick_report reports_due [$];

    logic [7:0] frame_pay [PAYLOAD_LEN];
    bit         tx_idling;
    bit         rx_idling;
    int         rx_hold_cycles;
    int         words_sent;
    int         err_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #5ms;
        $display("remote_frame_crc_parser_core_test: errors");
        $finish;
    end

    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] acc,
                                                      input logic [7:0] data);
        logic [CRC_W-1:0] r;
        r = acc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic restart_hunt();
        hunt_q = PH_HUNT;
        fill_q = 0;
        crc_q  = CRC_INIT;
    endtask

    task automatic decode_report(input logic status);
        logic [PAY_W-1:0] pv;
        t_stick_report    r;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            pv[i*8 +: 8] = last_good_q[i];
        end
        r.status   = status;
        r.right_h  = pv[0 +: 11];
        r.right_v  = pv[11 +: 11];
        r.left_v   = pv[22 +: 11];
        r.left_h   = pv[33 +: 11];
        r.wheel    = pv[49 +: 11];
        r.switches = {pv[60], pv[48], pv[47], pv[46], pv[45:44]};
        r.dx       = pv[64 +: 16];
        r.dy       = pv[80 +: 16];
        r.dz       = pv[96 +: 16];
        r.buttons  = {pv[117:116] == 2'b01, pv[115:114] == 2'b01, pv[113:112] == 2'b01};
        r.keys     = pv[120 +: 16];
        reports_due.push_back(r);
    endtask

    task automatic track_word(input logic cmd, input logic [7:0] b);
        if (cmd == CMD_IDLE) begin
            restart_hunt();
            burst_done_q = 1'b0;
            return;
        end
        if (burst_done_q) begin
            return;
        end
        if (hunt_q == PH_SECOND) begin
            if (b == hdr_second_q) begin
                frame_q[1] = b;
                crc_q      = crc16_update(crc_q, b);
                fill_q     = 2;
                hunt_q     = PH_COLLECT;
                return;
            end
            restart_hunt();
        end
        if (hunt_q == PH_HUNT) begin
            if (b == hdr_first_q) begin
                frame_q[0] = b;
                crc_q      = crc16_update(CRC_INIT, b);
                fill_q     = 1;
                hunt_q     = PH_SECOND;
            end
            return;
        end
        frame_q[fill_q] = b;
        if (fill_q < 19) begin
            crc_q = crc16_update(crc_q, b);
        end
        fill_q++;
        if (fill_q < FRAME_LEN) begin
            return;
        end
        if (crc_q == {frame_q[20], frame_q[19]}) begin
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                last_good_q[i] = frame_q[i + 2];
            end
            decode_report(1'b0);
        end else begin
            decode_report(1'b1);
        end
        burst_done_q = 1'b1;
        restart_hunt();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
            err_count++;
        end
    endtask

    // Compare each taken result with the oldest pending report.
    always @(posedge i_clk) begin
        t_stick_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: result with no frame pending", $realtime);
                err_count++;
            end else begin
                want = reports_due.pop_front();
                report_mismatch("status", o_status, want.status);
                report_mismatch("right_horizontal", o_right_horizontal, want.right_h);
                report_mismatch("right_vertical", o_right_vertical, want.right_v);
                report_mismatch("left_vertical", o_left_vertical, want.left_v);
                report_mismatch("left_horizontal", o_left_horizontal, want.left_h);
                report_mismatch("thumb_wheel", o_thumb_wheel, want.wheel);
                report_mismatch("switch_bits", o_switch_bits, want.switches);
                report_mismatch("pointer_dx", o_pointer_dx, want.dx);
                report_mismatch("pointer_dy", o_pointer_dy, want.dy);
                report_mismatch("pointer_dz", o_pointer_dz, want.dz);
                report_mismatch("pointer_buttons", o_pointer_buttons, want.buttons);
                report_mismatch("key_mask", o_key_mask, want.keys);
            end
        end
    end

    // Result side: random stalls, or a long hold counted here cycle by cycle.
    initial begin : result_taker
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                @(posedge i_clk);
                rx_hold_cycles--;
            end else begin
                n = rx_idling ? $urandom_range(0, 5) : 0;
                if (n > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid && rx_hold_cycles == 0);
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [7:0] b);
        int gap;
        gap = tx_idling ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_word(cmd, b);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(CMD_BYTE, b);
    endtask

    task automatic send_idle();
        send_word(CMD_IDLE, 8'($urandom_range(0, 255)));
    endtask

    // Sends the first n_bytes of a frame built from frame_pay under the current headers.
    task automatic send_frame(input bit corrupt, input int n_bytes);
        logic [7:0]       bytes [FRAME_LEN];
        logic [CRC_W-1:0] c;
        bytes[0] = hdr_first_q;
        bytes[1] = hdr_second_q;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            bytes[i + 2] = frame_pay[i];
        end
        c = CRC_INIT;
        for (int i = 0; i < 19; i++) begin
            c = crc16_update(c, bytes[i]);
        end
        if (corrupt) begin
            c = c ^ CRC_W'($urandom_range(1, 65535));
        end
        bytes[19] = c[7:0];
        bytes[20] = c[15:8];
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(bytes[i]);
        end
    endtask

    task automatic fill_payload(input int mode);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            case (mode)
                0: frame_pay[i] = 8'h00;
                1: frame_pay[i] = 8'hFF;
                2: frame_pay[i] = 8'h55;
                3: frame_pay[i] = 8'hAA;
                4: frame_pay[i] = ($urandom_range(0, 1)) ? hdr_first_q : hdr_second_q;
                default: frame_pay[i] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    // Holds the sender back until every pending report has been taken and the block
    // has had time to settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_IDX_HDR_FIRST) begin
            hdr_first_q = val;
        end else if (idx == CFG_IDX_HDR_SECOND) begin
            hdr_second_q = val;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
        drain_results();
        write_register(CFG_IDX_HDR_FIRST, first);
        write_register(CFG_IDX_HDR_SECOND, second);
    endtask

    task automatic test_reset_headers();
        // A CRC error before any good frame must report all-zero values.
        fill_payload(5);
        send_frame(1'b1, FRAME_LEN);
        send_idle();
        for (int m = 0; m < 4; m++) begin
            fill_payload(m);
            send_frame(1'b0, FRAME_LEN);
            send_idle();
        end
        fill_payload(5);
        send_frame(1'b0, FRAME_LEN);
        send_idle();
        // A bad frame after a good one repeats the good values.
        fill_payload(1);
        send_frame(1'b1, FRAME_LEN);
        send_idle();
    endtask

    task automatic test_special_sequences();
        fill_payload(5);
        send_byte(hdr_first_q);
        send_frame(1'b0, FRAME_LEN);
        send_idle();
        send_byte(hdr_first_q);
        send_byte(hdr_second_q ^ 8'h01);
        fill_payload(4);
        send_frame(1'b0, FRAME_LEN);
        // The rest of this burst is ignored, even a complete frame.
        fill_payload(5);
        send_frame(1'b0, FRAME_LEN);
        send_byte(hdr_first_q);
        send_idle();
        send_frame(1'b0, 12);
        send_idle();
        send_frame(1'b0, 20);
        send_idle();
        send_frame(1'b0, FRAME_LEN);
        send_idle();
    endtask

    task automatic test_header_registers();
        set_headers(8'h00, 8'hFF);
        fill_payload(0);
        send_frame(1'b0, FRAME_LEN);
        send_idle();
        set_headers(8'hFF, 8'h00);
        fill_payload(1);
        send_frame(1'b0, FRAME_LEN);
        send_idle();
        set_headers(8'h5A, 8'h5A);
        fill_payload(4);
        send_byte(8'h5A);
        send_frame(1'b0, FRAME_LEN);
        send_idle();
        set_headers(HDR_FIRST_RST, HDR_SECOND_RST);
    endtask

    task automatic test_output_stall();
        tx_idling      = 1'b0;
        rx_hold_cycles = 300;
        for (int f = 0; f < 4; f++) begin
            fill_payload(5);
            send_frame($urandom_range(0, 3) == 0, FRAME_LEN);
            send_idle();
        end
        tx_idling = 1'b1;
        drain_results();
    endtask

    task automatic random_burst();
        int kind;
        int n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        fill_payload(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 5);
        if (kind < 70) begin
            send_frame($urandom_range(0, 6) == 0, FRAME_LEN);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0) begin
                send_frame(1'b0, FRAME_LEN);
            end
        end else if (kind < 80) begin
            send_frame(1'b0, $urandom_range(1, FRAME_LEN - 1));
        end else if (kind < 88) begin
            b = 8'($urandom_range(0, 255));
            if (b == hdr_second_q) begin
                b = b ^ 8'h80;
            end
            send_byte(hdr_first_q);
            send_byte(b);
            send_frame(1'b0, FRAME_LEN);
        end else if (kind < 94) begin
            send_byte(hdr_first_q);
            send_frame($urandom_range(0, 4) == 0, FRAME_LEN);
        end else begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            send_idle();
        end
    endtask

    // Random bursts fill up the run to about 850 words in total.
    task automatic test_random_traffic();
        int word_goal;
        int bursts;
        word_goal = 850;
        bursts    = 0;
        while (words_sent < word_goal) begin
            if (bursts % 6 == 0) begin
                tx_idling = $urandom_range(0, 3) != 0;
                rx_idling = $urandom_range(0, 3) != 0;
            end
            if (bursts % 10 == 9) begin
                case ($urandom_range(0, 3))
                    0: set_headers(8'h00, 8'hFF);
                    1: set_headers(8'hFF, 8'h00);
                    2: set_headers(HDR_FIRST_RST, HDR_SECOND_RST);
                    default: set_headers(8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)));
                endcase
            end
            random_burst();
            bursts++;
        end
    endtask

    initial begin : run
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_BYTE;
        i_rx_byte      = 8'h00;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_IDX_HDR_FIRST;
        i_cfg_data     = 8'h00;
        hdr_first_q    = HDR_FIRST_RST;
        hdr_second_q   = HDR_SECOND_RST;
        burst_done_q   = 1'b0;
        tx_idling      = 1'b1;
        rx_idling      = 1'b1;
        rx_hold_cycles = 0;
        words_sent     = 0;
        err_count      = 0;
        restart_hunt();
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            last_good_q[i] = 8'h00;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_headers();
        test_special_sequences();
        test_header_registers();
        test_output_stall();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            $display("%0d frame results never arrived", reports_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("remote_frame_crc_parser_core_test: clean");
        end else begin
            $display("remote_frame_crc_parser_core_test: errors");
        end
        $finish;
    end

endmodule
